FILE: rtl/lfed_pkg.sv
package lfed_pkg;

    // valid bits of the sample field
    localparam int unsigned SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // detection phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SLOPE = 2'd1;
    localparam logic [1:0] PH_AMP   = 2'd2;
    localparam logic [1:0] PH_HOT   = 2'd3;

    // input functions
    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_CLEAR  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 17;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMP_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_OBS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO_HI  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO_LO  = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_AMP_THR   = 16'd65535;
    localparam logic [16:0] RST_SLOPE_THR = 17'd65535;
    localparam logic [15:0] RST_MIN_OBS   = 16'd8;
    localparam logic [15:0] RST_RATIO_HI  = 16'd52429;
    localparam logic [15:0] RST_RATIO_LO  = 16'd32768;

    // count guard
    localparam logic [15:0] COUNT_LIMIT = 16'd65534;
    // ceil(2^19 / 10), exact quotient for any 16 bit dividend
    localparam logic [31:0] DIV10_RECIP = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic        func;
        logic [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [1:0] phase;
        logic       rising;
        logic       amp_hit;
        logic       slope_hit;
        logic       false_positive;
    } t_out_word;

    function automatic logic [15:0] div10(input logic [15:0] n);
        logic [31:0] prod;
        prod = {16'd0, n} * DIV10_RECIP;
        return 16'(prod >> DIV10_SHIFT);
    endfunction

endpackage

FILE: rtl/light_flash_event_detector_unit.sv
// Light flash event detector: one word per sample (or a clear-alarm command) in, one
// result word out per input word. The block takes a new word in every clock cycle
// unless o_in_stall is high. Each word passes from the input register through the hit
// compares, the phase update and one 16x16 ratio multiply into the result register,
// which also updates the previous sample, phase and counts. A separate output register
// lets the next word enter while a result waits to be taken. Configuration writes are
// always ready and take effect on the next sample; write them only while the block is
// idle.
module light_flash_event_detector_unit
    import lfed_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_word                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [15:0] r_amp_thr;
    logic [16:0] r_slope_thr;
    logic [15:0] r_min_obs;
    logic [15:0] r_ratio_hi;
    logic [15:0] r_ratio_lo;

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [15:0] r_prev;
    logic [1:0]  r_phase;
    logic [15:0] r_obs;
    logic [15:0] r_pos;

    logic [15:0] n_prev;
    logic [1:0]  n_phase;
    logic [15:0] n_obs;
    logic [15:0] n_pos;
    t_out_word   n_out;

    logic        out_free;
    logic        adv;
    logic        in_free;

    logic [15:0] s;
    logic [16:0] rise;
    logic        rising;
    logic        amp_hit;
    logic        slope_hit;
    logic        pos_cond;
    logic [15:0] obs_mid;
    logic [15:0] pos_mid;
    logic [15:0] limit;
    logic [31:0] limit_prod;
    logic [31:0] pos_scaled;
    logic        ratio_above;
    logic        ratio_below;
    logic        fp;

    // handshake: output register frees the input register
    assign out_free    = !r_out_valid || !i_out_stall;
    assign adv         = r_in_valid && out_free;
    assign in_free     = !r_in_valid || adv;
    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_thr   <= RST_AMP_THR;
            r_slope_thr <= RST_SLOPE_THR;
            r_min_obs   <= RST_MIN_OBS;
            r_ratio_hi  <= RST_RATIO_HI;
            r_ratio_lo  <= RST_RATIO_LO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_AMP_THR:   r_amp_thr   <= i_cfg_data[15:0];
                CFG_SLOPE_THR: r_slope_thr <= i_cfg_data;
                CFG_MIN_OBS:   r_min_obs   <= i_cfg_data[15:0];
                CFG_RATIO_HI:  r_ratio_hi  <= i_cfg_data[15:0];
                CFG_RATIO_LO:  r_ratio_lo  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sample compares
    assign s         = r_in.sample & SAMPLE_MASK;
    assign rise      = {1'b0, s} - {1'b0, r_prev};
    assign rising    = s > r_prev;
    assign slope_hit = $signed(rise) > $signed(r_slope_thr);
    assign amp_hit   = s > r_amp_thr;

    // counts after this observation, before the phase decision
    assign pos_cond = (r_phase == PH_AMP) ? amp_hit : (amp_hit || slope_hit);
    assign obs_mid  = r_obs + 16'd1;
    assign pos_mid  = pos_cond ? (r_pos + 16'd1) : r_pos;

    // exact ratio test: pos * 2^16 against limit * obs
    assign limit       = (r_phase == PH_HOT) ? r_ratio_lo : r_ratio_hi;
    assign limit_prod  = {16'd0, limit} * {16'd0, obs_mid};
    assign pos_scaled  = {pos_mid, 16'd0};
    assign ratio_above = pos_scaled > limit_prod;
    assign ratio_below = pos_scaled < limit_prod;

    always_comb begin
        n_prev  = r_prev;
        n_phase = r_phase;
        n_obs   = r_obs;
        n_pos   = r_pos;
        fp      = 1'b0;
        n_out   = '0;
        if (r_in.func == FN_CLEAR) begin
            fp      = (r_phase != PH_IDLE);
            n_phase = PH_IDLE;
        end else begin
            n_prev = s;
            unique case (r_phase) inside
                PH_IDLE: begin
                    if (amp_hit || slope_hit) begin
                        n_obs   = 16'd1;
                        n_pos   = 16'd1;
                        n_phase = amp_hit ? PH_AMP : PH_SLOPE;
                    end
                end
                PH_SLOPE, PH_AMP: begin
                    n_obs = obs_mid;
                    n_pos = pos_mid;
                    if (amp_hit) begin
                        n_phase = PH_AMP;
                    end
                    if (obs_mid >= r_min_obs) begin
                        if (ratio_above) begin
                            n_phase = PH_HOT;
                        end else begin
                            n_phase = PH_IDLE;
                            fp      = 1'b1;
                        end
                    end
                end
                PH_HOT: begin
                    n_obs = obs_mid;
                    n_pos = pos_mid;
                    if (ratio_below) begin
                        n_phase = PH_IDLE;
                        fp      = 1'b1;
                    end
                end
            endcase
            // keep the counts from wrapping
            if (r_phase != PH_IDLE && (obs_mid > COUNT_LIMIT || pos_mid > COUNT_LIMIT)) begin
                n_obs = div10(obs_mid);
                n_pos = div10(pos_mid);
            end
            n_out.rising    = rising;
            n_out.amp_hit   = amp_hit;
            n_out.slope_hit = slope_hit;
        end
        n_out.phase          = n_phase;
        n_out.false_positive = fp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_phase     <= PH_IDLE;
            r_obs       <= '0;
            r_pos       <= '0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= adv;
            end
            if (adv) begin
                r_prev  <= n_prev;
                r_phase <= n_phase;
                r_obs   <= n_obs;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/lfed_checker.sv
module lfed_checker
    import lfed_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     o_in_stall,
    input  t_in_word                 i_in_data,
    input  logic                     o_out_valid,
    input  logic                     i_out_stall,
    input  t_out_word                o_out_data,
    input  logic                     i_cfg_valid,
    input  logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // with the output register empty the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register empty");

    // a fallback always lands in idle
    a_fp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.false_positive |-> o_out_data.phase == PH_IDLE)
        else $error("false positive outside idle");

endmodule

bind light_flash_event_detector_unit lfed_checker u_lfed_checker (.*);
